@@ rtl/central_gravity_derivative_core_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef CENTRAL_GRAVITY_DERIVATIVE_CORE_DEFINES_SVH
`define CENTRAL_GRAVITY_DERIVATIVE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CGD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/cgd_pkg.sv @@
package cgd_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int COORD_FRAC = 16;
	localparam int GM_WIDTH = 48;
	localparam int ACC_WIDTH = 48;
	localparam logic [GM_WIDTH-1:0] GM_RESET = 48'd65536000;
	// Digit width of the partial-product multipliers.
	localparam int LIMB = 32;

	// Cycles a cgd_mul takes for a multiplier operand of the given width.
	function automatic int mul_lat(input int bw);
		return 2 * ((bw + LIMB - 1) / LIMB);
	endfunction

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction
endpackage

@@ rtl/cgd_mul.sv @@
// Pipelined unsigned multiplier: one row of limb products per cell, two stages per cell.
module cgd_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic              clk,
	input  logic              en,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	output logic [AW+BW-1:0]  p
);
	localparam int LW = cgd_pkg::LIMB;
	localparam int NA = (AW + LW - 1) / LW;
	localparam int NB = (BW + LW - 1) / LW;
	localparam int PAW = NA * LW;
	localparam int PBW = NB * LW;
	localparam int ACW = PAW + PBW;
	localparam int RW = PAW + 2 * LW;

	logic [PAW-1:0] a_c [NB+1];
	logic [PBW-1:0] b_c [NB+1];
	logic [ACW-1:0] acc_c [NB+1];

	assign a_c[0] = PAW'(a);
	assign b_c[0] = PBW'(b);
	assign acc_c[0] = '0;

	for (genvar j = 0; j < NB; j++) begin : g_row
		logic [2*LW-1:0] pp_s1 [NA];
		logic [PAW-1:0]  a_s1, a_s2;
		logic [PBW-1:0]  b_s1, b_s2;
		logic [ACW-1:0]  acc_s1, acc_s2;
		logic [RW-1:0]   even_c, odd_c;

		// Even and odd limb products do not overlap among themselves.
		always_comb begin
			even_c = '0;
			odd_c = '0;
			for (int i = 0; i < NA; i++) begin
				if ((i & 1) == 0) begin
					even_c[i*LW +: 2*LW] = pp_s1[i];
				end else begin
					odd_c[i*LW +: 2*LW] = pp_s1[i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < NA; i++) begin
					pp_s1[i] <= (2*LW)'(a_c[j][i*LW +: LW]) * (2*LW)'(b_c[j][j*LW +: LW]);
				end
				a_s1 <= a_c[j];
				b_s1 <= b_c[j];
				acc_s1 <= acc_c[j];
				a_s2 <= a_s1;
				b_s2 <= b_s1;
				acc_s2 <= acc_s1 + (ACW'(even_c + odd_c) << (j * LW));
			end
		end

		assign a_c[j+1] = a_s2;
		assign b_c[j+1] = b_s2;
		assign acc_c[j+1] = acc_s2;
	end

	assign p = acc_c[NB][AW+BW-1:0];
endmodule

@@ rtl/cgd_dly.sv @@
// Shift line that keeps data in step with the multiplier pipelines.
module cgd_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	if (N == 0) begin : g_none
		assign q = d;
	end else begin : g_line
		logic [W-1:0] line_q [N];

		always_ff @(posedge clk) begin
			if (en) begin
				line_q[0] <= d;
				for (int i = 1; i < N; i++) begin
					line_q[i] <= line_q[i-1];
				end
			end
		end

		assign q = line_q[N-1];
	end
endmodule

@@ rtl/cgd_root_cell.sv @@
// One bit of k = floor(N / S^1.5), decided by k^2 * S^3 <= N^2.
// r is N^2 - k^2*S^3, q is k*S^3; trying bit BIT costs q*2^(BIT+1) + S^3*2^(2*BIT).
module cgd_root_cell #(
	parameter int S3W = 192,
	parameter int QW = 240,
	parameter int NRW = 256,
	parameter int KW = 48,
	parameter int SBW = 1,
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NRW-1:0] r_i [3],
	input  logic [QW-1:0]  q_i [3],
	input  logic [KW-1:0]  k_i [3],
	input  logic [S3W-1:0] s3_i,
	input  logic [SBW-1:0] sb_i,
	output logic [NRW-1:0] r_o [3],
	output logic [QW-1:0]  q_o [3],
	output logic [KW-1:0]  k_o [3],
	output logic [S3W-1:0] s3_o,
	output logic [SBW-1:0] sb_o
);
	localparam int CMW = cgd_pkg::max_int(QW + KW + 1, NRW) + 1;

	logic [CMW-1:0] d_c [3];
	logic [CMW-1:0] rem_c [3];
	logic           take_c [3];
	logic [NRW-1:0] r_q [3];
	logic [QW-1:0]  q_q [3];
	logic [KW-1:0]  k_q [3];
	logic [S3W-1:0] s3_q;
	logic [SBW-1:0] sb_q;

	// Once the top bit of k is set the value is at its limit and no lower bit is tried.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d_c[c] = (CMW'(q_i[c]) << (BIT + 1)) + (CMW'(s3_i) << (2 * BIT));
			rem_c[c] = CMW'(r_i[c]) - d_c[c];
			take_c[c] = ((BIT == KW - 1) || !k_i[c][KW-1]) && (d_c[c] <= CMW'(r_i[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				r_q[c] <= take_c[c] ? rem_c[c][NRW-1:0] : r_i[c];
				q_q[c] <= take_c[c] ? q_i[c] + (QW'(s3_i) << BIT) : q_i[c];
				k_q[c] <= k_i[c] | (take_c[c] ? (KW'(1) << BIT) : '0);
			end
			s3_q <= s3_i;
			sb_q <= sb_i;
		end
	end

	assign r_o = r_q;
	assign q_o = q_q;
	assign k_o = k_q;
	assign s3_o = s3_q;
	assign sb_o = sb_q;
endmodule

@@ rtl/central_gravity_derivative_core.sv @@
// Path from input to output transaction: input register, component multipliers, sum register,
// the S^3 and N^2 multiplier pipelines (the shorter one padded by delay lines), the root chain
// and the output buffer register.
// Throughput: one body per cycle; the 48-cell root chain and the multipliers are fully pipelined.
// The pipeline stalls only when its two-entry output buffer is full.
// Reset clears all valid state and the output buffer; gm resets to 1000.0 (Q32.16).
module central_gravity_derivative_core #(
	parameter int COORD_WIDTH = cgd_pkg::COORD_WIDTH,
	parameter int COORD_FRAC = cgd_pkg::COORD_FRAC
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cgd_pkg::GM_WIDTH-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 is_fixed,
	input  logic signed [COORD_WIDTH-1:0]        pos_x,
	input  logic signed [COORD_WIDTH-1:0]        pos_y,
	input  logic signed [COORD_WIDTH-1:0]        pos_z,
	input  logic signed [COORD_WIDTH-1:0]        vel_x,
	input  logic signed [COORD_WIDTH-1:0]        vel_y,
	input  logic signed [COORD_WIDTH-1:0]        vel_z,
	input  logic                                 last_body,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [COORD_WIDTH-1:0]        dpos_x,
	output logic signed [COORD_WIDTH-1:0]        dpos_y,
	output logic signed [COORD_WIDTH-1:0]        dpos_z,
	output logic signed [cgd_pkg::ACC_WIDTH-1:0] acc_x,
	output logic signed [cgd_pkg::ACC_WIDTH-1:0] acc_y,
	output logic signed [cgd_pkg::ACC_WIDTH-1:0] acc_z,
	output logic                                 at_origin,
	output logic                                 last_out
);
	localparam int CW = COORD_WIDTH;
	localparam int GW = cgd_pkg::GM_WIDTH;
	localparam int KW = cgd_pkg::ACC_WIDTH;
	localparam int E = 2 * COORD_FRAC + 16;
	localparam int SW = 2 * CW;
	localparam int S2W = 2 * SW;
	localparam int S3W = 3 * SW;
	localparam int NW = GW + CW;
	localparam int N2W = 2 * NW;
	localparam int NRW = N2W + 2 * E;
	localparam int QW = S3W + KW;
	localparam int L1 = cgd_pkg::mul_lat(CW);
	localparam int L2 = cgd_pkg::mul_lat(SW);
	localparam int L3 = cgd_pkg::mul_lat(NW);
	localparam int TA = cgd_pkg::max_int(2 * L2, L3);
	localparam int SBW = 3 * CW + 5;
	localparam int SB2W = SBW + 1;
	localparam int LT = 1 + L1 + 1 + TA + KW;
	localparam int OW = 3 * CW + 3 * KW + 2;

	logic [GW-1:0]   gm_q;
	logic [LT-1:0]   vld_q;
	logic            en;
	logic            push;
	logic            pop;
	logic [1:0]      cnt_q;
	logic [OW-1:0]   hd_q, tl_q, res_c;

	logic signed [CW-1:0] pos_c [3];
	logic signed [CW-1:0] vel_c [3];
	logic [CW-1:0]   mag_c [3];
	logic [CW-1:0]   mag_s1 [3];
	logic [2:0]      neg_s1;
	logic [CW-1:0]   vel_s1 [3];
	logic            fixed_s1, last_s1;
	logic [SW-1:0]   sq_c [3];
	logic [NW-1:0]   nn_c [3];
	logic [SBW-1:0]  sb1_c, sb1_d;
	logic [SW-1:0]   s_s2;
	logic [NW-1:0]   n_s2 [3];
	logic [SBW-1:0]  sb_s2;
	logic [S2W-1:0]  s2p_c;
	logic [SW-1:0]   s_d;
	logic [S3W-1:0]  s3p_c, s3_a;
	logic [N2W-1:0]  n2p_c [3];
	logic [N2W-1:0]  n2_a [3];
	logic [SB2W-1:0] sb_a;

	logic [NRW-1:0]  r_ch [KW+1][3];
	logic [QW-1:0]   q_ch [KW+1][3];
	logic [KW-1:0]   k_ch [KW+1][3];
	logic [S3W-1:0]  s3_ch [KW+1];
	logic [SB2W-1:0] sb_ch [KW+1];

	logic [SB2W-1:0] sb_f;
	logic            fixed_f, origin_f, last_f;
	logic [KW-1:0]   acc_f [3];
	logic [CW-1:0]   dpos_f [3];
	logic [KW-1:0]   sat_f;

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm_q <= cgd_pkg::GM_RESET;
		end else if (cfg_valid) begin
			gm_q <= cfg_data;
		end
	end

	// Input stage: component magnitudes and signs.
	assign pos_c[0] = pos_x;
	assign pos_c[1] = pos_y;
	assign pos_c[2] = pos_z;
	assign vel_c[0] = vel_x;
	assign vel_c[1] = vel_y;
	assign vel_c[2] = vel_z;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag_c[c] = pos_c[c][CW-1] ? CW'(-pos_c[c]) : CW'(pos_c[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag_s1[c] <= mag_c[c];
				neg_s1[c] <= pos_c[c][CW-1];
				vel_s1[c] <= vel_c[c];
			end
			fixed_s1 <= is_fixed;
			last_s1 <= last_body;
		end
	end

	// Squares of the components, gm times each magnitude, and the square of each such product.
	for (genvar c = 0; c < 3; c++) begin : g_comp
		cgd_mul #(.AW(CW), .BW(CW)) u_sq (
			.clk(clk), .en(en), .a(mag_s1[c]), .b(mag_s1[c]), .p(sq_c[c])
		);
		cgd_mul #(.AW(GW), .BW(CW)) u_gmm (
			.clk(clk), .en(en), .a(gm_q), .b(mag_s1[c]), .p(nn_c[c])
		);
		cgd_mul #(.AW(NW), .BW(NW)) u_n2 (
			.clk(clk), .en(en), .a(n_s2[c]), .b(n_s2[c]), .p(n2p_c[c])
		);
		cgd_dly #(.W(N2W), .N(TA - L3)) u_n2_dly (
			.clk(clk), .en(en), .d(n2p_c[c]), .q(n2_a[c])
		);
	end

	assign sb1_c = {vel_s1[2], vel_s1[1], vel_s1[0], neg_s1, fixed_s1, last_s1};

	cgd_dly #(.W(SBW), .N(L1)) u_sb1_dly (
		.clk(clk), .en(en), .d(sb1_c), .q(sb1_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= sq_c[0] + sq_c[1] + sq_c[2];
			n_s2 <= nn_c;
			sb_s2 <= sb1_d;
		end
	end

	// S^3 in two multiplier passes.
	cgd_mul #(.AW(SW), .BW(SW)) u_s2 (
		.clk(clk), .en(en), .a(s_s2), .b(s_s2), .p(s2p_c)
	);

	cgd_dly #(.W(SW), .N(L2)) u_s_dly (
		.clk(clk), .en(en), .d(s_s2), .q(s_d)
	);

	cgd_mul #(.AW(S2W), .BW(SW)) u_s3 (
		.clk(clk), .en(en), .a(s2p_c), .b(s_d), .p(s3p_c)
	);

	cgd_dly #(.W(S3W), .N(TA - 2 * L2)) u_s3_dly (
		.clk(clk), .en(en), .d(s3p_c), .q(s3_a)
	);

	cgd_dly #(.W(SB2W), .N(TA)) u_sb2_dly (
		.clk(clk), .en(en), .d({sb_s2, (s_s2 == '0)}), .q(sb_a)
	);

	// Root chain, most significant bit first.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			r_ch[0][c] = {n2_a[c], {(2 * E){1'b0}}};
			q_ch[0][c] = '0;
			k_ch[0][c] = '0;
		end
	end
	assign s3_ch[0] = s3_a;
	assign sb_ch[0] = sb_a;

	for (genvar i = 0; i < KW; i++) begin : g_root
		cgd_root_cell #(
			.S3W(S3W), .QW(QW), .NRW(NRW), .KW(KW), .SBW(SB2W), .BIT(KW - 1 - i)
		) u_cell (
			.clk(clk), .en(en),
			.r_i(r_ch[i]), .q_i(q_ch[i]), .k_i(k_ch[i]), .s3_i(s3_ch[i]), .sb_i(sb_ch[i]),
			.r_o(r_ch[i+1]), .q_o(q_ch[i+1]), .k_o(k_ch[i+1]), .s3_o(s3_ch[i+1]),
			.sb_o(sb_ch[i+1])
		);
	end

	// Sign, saturation and the special bodies.
	assign sb_f = sb_ch[KW];
	assign origin_f = sb_f[0];
	assign last_f = sb_f[1];
	assign fixed_f = sb_f[2];
	assign sat_f = {1'b0, {(KW - 1){1'b1}}};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (fixed_f || origin_f) begin
				acc_f[c] = '0;
			end else if (sb_f[3 + c]) begin
				acc_f[c] = k_ch[KW][c][KW-1] ? sat_f : k_ch[KW][c];
			end else begin
				acc_f[c] = -k_ch[KW][c];
			end
			dpos_f[c] = fixed_f ? '0 : sb_f[6 + c * CW +: CW];
		end
	end

	assign res_c = {last_f, (origin_f && !fixed_f), acc_f[2], acc_f[1], acc_f[0],
		dpos_f[2], dpos_f[1], dpos_f[0]};

	// Valid line and two-entry output buffer.
	assign en = (cnt_q != 2'd2);
	assign in_ready = en;
	assign push = vld_q[LT-1] && en;
	assign pop = (cnt_q != 2'd0) && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= 2'd0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[LT-2:0], in_valid};
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				hd_q <= tl_q;
			end else if (push) begin
				hd_q <= res_c;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				hd_q <= res_c;
			end else begin
				tl_q <= res_c;
			end
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign dpos_x = hd_q[0 +: CW];
	assign dpos_y = hd_q[CW +: CW];
	assign dpos_z = hd_q[2*CW +: CW];
	assign acc_x = hd_q[3*CW +: KW];
	assign acc_y = hd_q[3*CW + KW +: KW];
	assign acc_z = hd_q[3*CW + 2*KW +: KW];
	assign at_origin = hd_q[OW-2];
	assign last_out = hd_q[OW-1];
endmodule

@@ rtl/cgd_checker.sv @@
`include "central_gravity_derivative_core_defines.svh"

module cgd_checker #(
	parameter int COORD_WIDTH = cgd_pkg::COORD_WIDTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [COORD_WIDTH-1:0]        dpos_x,
	input logic [cgd_pkg::ACC_WIDTH-1:0] acc_x,
	input logic [cgd_pkg::ACC_WIDTH-1:0] acc_y,
	input logic [cgd_pkg::ACC_WIDTH-1:0] acc_z,
	input logic                          at_origin,
	input logic                          last_out
);
	// A body at the origin never reports an acceleration.
	`CGD_ASSERT_SAME(a_origin_zero, out_valid && at_origin, acc_x == '0 && acc_y == '0 && acc_z == '0)

	// Input is refused only while results are waiting in the output buffer.
	`CGD_ASSERT_SAME(a_stall_has_output, !in_ready, out_valid)

	// A waiting output transaction holds its payload.
	`CGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(acc_x) && $stable(dpos_x) && $stable(last_out))
endmodule

bind central_gravity_derivative_core cgd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cgd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.dpos_x(dpos_x),
	.acc_x(acc_x),
	.acc_y(acc_y),
	.acc_z(acc_z),
	.at_origin(at_origin),
	.last_out(last_out)
);

@@ tb/central_gravity_derivative_core_tb.sv @@
module central_gravity_derivative_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_WIDTH = cgd_pkg::COORD_WIDTH;
	localparam int COORD_FRAC = cgd_pkg::COORD_FRAC;
	localparam int ACC_WIDTH = cgd_pkg::ACC_WIDTH;
	localparam int GM_WIDTH = cgd_pkg::GM_WIDTH;
	localparam logic [GM_WIDTH-1:0] GM_RESET = cgd_pkg::GM_RESET;
	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [GM_WIDTH-1:0] GM_FULL = '1;

	typedef struct packed {
		logic                          is_fixed;
		logic signed [COORD_WIDTH-1:0] px, py, pz;
		logic signed [COORD_WIDTH-1:0] vx, vy, vz;
		logic                          last;
	} body_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] dx, dy, dz;
		logic signed [ACC_WIDTH-1:0]   ax, ay, az;
		logic                          origin;
		logic                          last;
	} deriv_t;

	class deriv_scoreboard;
		logic [GM_WIDTH-1:0] gm_q = GM_RESET;
		deriv_t pending[$];
		int mismatches = 0;
		int bodies = 0;
		int derivs = 0;
		int saturated = 0;

		// Exact truncated value of gm*|c|*2^(2F+16) / S^(3/2) by bitwise root search, signed toward the origin and saturated.
		function logic [ACC_WIDTH-1:0] pull(logic signed [COORD_WIDTH-1:0] c,
				logic [299:0] s3);
			logic neg;
			logic [COORD_WIDTH-1:0] mag;
			logic [299:0] num, num2, k, cand;
			neg = c[COORD_WIDTH-1];
			mag = neg ? -c : c;
			if (mag == 0 || gm_q == 0)
				return '0;
			num = ({252'd0, gm_q} * mag) << (2 * COORD_FRAC + 16);
			num2 = num * num;
			k = '0;
			for (int b = ACC_WIDTH - 1; b >= 0; b--) begin
				cand = k | (300'd1 << b);
				if (cand > (300'd1 << (ACC_WIDTH - 1)))
					continue;
				if (cand * cand * s3 <= num2)
					k = cand;
			end
			if (k >= (300'd1 << (ACC_WIDTH - 1)))
				saturated++;
			if (neg)
				return (k >= (300'd1 << (ACC_WIDTH - 1))) ? ACC_MAX : k[ACC_WIDTH-1:0];
			return -k[ACC_WIDTH-1:0];
		endfunction

		function void note_body(body_t b);
			deriv_t d;
			logic [299:0] s, s3, m;
			d = '{default: '0};
			d.last = b.last;
			bodies++;
			if (!b.is_fixed) begin
				d.dx = b.vx;
				d.dy = b.vy;
				d.dz = b.vz;
				s = '0;
				m = b.px[COORD_WIDTH-1] ? -b.px : b.px; s += m * m;
				m = b.py[COORD_WIDTH-1] ? -b.py : b.py; s += m * m;
				m = b.pz[COORD_WIDTH-1] ? -b.pz : b.pz; s += m * m;
				if (s == 0)
					d.origin = 1'b1;
				else begin
					s3 = s * s * s;
					d.ax = pull(b.px, s3);
					d.ay = pull(b.py, s3);
					d.az = pull(b.pz, s3);
				end
			end
			pending.push_back(d);
		endfunction

		function void check_deriv(deriv_t got);
			deriv_t e;
			derivs++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected derivative transaction at %0t", $realtime);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at %0t: exp d=%h %h %h a=%h %h %h o=%b l=%b",
						" got d=%h %h %h a=%h %h %h o=%b l=%b"},
						$realtime, e.dx, e.dy, e.dz, e.ax, e.ay, e.az, e.origin, e.last,
						got.dx, got.dy, got.dz, got.ax, got.ay, got.az, got.origin, got.last);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [GM_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 0, in_ready;
	logic is_fixed = 0, last_body = 0;
	logic signed [COORD_WIDTH-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [COORD_WIDTH-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic out_valid, out_ready = 0;
	logic signed [COORD_WIDTH-1:0] dpos_x, dpos_y, dpos_z;
	logic signed [ACC_WIDTH-1:0] acc_x, acc_y, acc_z;
	logic at_origin, last_out;
	logic steady = 0;

	deriv_scoreboard sb = new();

	always #5 clk = ~clk;

	central_gravity_derivative_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .is_fixed(is_fixed),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .last_body(last_body),
		.out_valid(out_valid), .out_ready(out_ready),
		.dpos_x(dpos_x), .dpos_y(dpos_y), .dpos_z(dpos_z),
		.acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
		.at_origin(at_origin), .last_out(last_out)
	);

	always @(negedge clk)
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 21);

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_body('{is_fixed, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, last_body});
		if (arst_n && out_valid && out_ready)
			sb.check_deriv('{dpos_x, dpos_y, dpos_z, acc_x, acc_y, acc_z, at_origin, last_out});
		if (arst_n && cfg_valid && cfg_ready)
			sb.gm_q = cfg_data;
	end

	task automatic send_body(body_t b);
		while (!steady && $urandom_range(0, 99) < 21)
			@(negedge clk);
		in_valid = 1;
		is_fixed = b.is_fixed;
		pos_x = b.px; pos_y = b.py; pos_z = b.pz;
		vel_x = b.vx; vel_y = b.vy; vel_z = b.vz;
		last_body = b.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain(int cycles);
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_gm(logic [GM_WIDTH-1:0] v);
		drain(150);
		cfg_valid = 1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Most coordinates are moderate so accelerations land in range; some span all bits.
	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick < 4)
			return $urandom();
		if (pick < 7)
			return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
		return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
	endfunction

	function automatic body_t rand_body();
		body_t b;
		b.is_fixed = ($urandom_range(0, 19) == 0);
		b.px = rand_coord();
		b.py = rand_coord();
		b.pz = rand_coord();
		if ($urandom_range(0, 29) == 0)
			{b.px, b.py, b.pz} = '0;
		b.vx = $urandom();
		b.vy = $urandom();
		b.vz = $urandom();
		b.last = $urandom_range(0, 1);
		return b;
	endfunction

	task automatic directed();
		logic signed [COORD_WIDTH-1:0] mn, mx, one;
		mn = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		mx = ~mn;
		one = 1;
		send_body('{1, mx, mn, one, mx, mn, -one, 1});
		send_body('{0, 0, 0, 0, mx, mn, one, 0});
		send_body('{0, 0, 0, 0, mn, mx, 0, 1});
		send_body('{0, mx, 0, 0, 0, 0, 0, 0});
		send_body('{0, mn, 0, 0, mx, mx, mx, 1});
		send_body('{0, mx, mx, mx, mn, mn, mn, 0});
		send_body('{0, mn, mn, mn, -one, -one, -one, 1});
		send_body('{0, one, 0, 0, 0, 0, 0, 0});
		send_body('{0, -one, 0, 0, 0, 0, 0, 0});
		send_body('{0, 0, one, -one, 0, 0, 0, 1});
		send_body('{0, 32'sh0001_0000, 0, 0, 0, 0, 0, 0});
		send_body('{0, 0, -32'sh0001_0000, 0, 0, 0, 0, 0});
		send_body('{0, 0, 0, 32'sh0064_0000, 0, 0, 0, 1});
		send_body('{0, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0});
		send_body('{0, mn, mx, one, 0, 0, 0, 0});
		send_body('{1, 0, 0, 0, 0, 0, 0, 1});
	endtask

	task automatic random_bodies(int n);
		repeat (n) send_body(rand_body());
	endtask

	initial begin
		#5000000;
		$display("timeout waiting for derivative transactions");
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		directed();
		random_bodies(300);
		write_gm(GM_FULL);
		directed();
		random_bodies(200);
		write_gm('0);
		directed();
		random_bodies(150);
		write_gm(48'd1);
		directed();
		steady = 1;
		random_bodies(300);
		steady = 0;
		write_gm({$urandom(), 16'(($urandom()))});
		random_bodies(250);
		write_gm(GM_RESET);
		random_bodies(300);
		drain(200);
		$display("covered %0d bodies and %0d derivatives over six gm settings, %0d saturated axes",
			sb.bodies, sb.derivs, sb.saturated);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else begin
			$display("%0d mismatches, %0d derivatives never arrived",
				sb.mismatches, sb.pending.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cgd_pkg.sv
rtl/cgd_mul.sv
rtl/cgd_dly.sv
rtl/cgd_root_cell.sv
rtl/central_gravity_derivative_core.sv
rtl/cgd_checker.sv
tb/central_gravity_derivative_core_tb.sv
